### hw/rtl/mlf_pkg.sv
// MAC learning forward table: shared types, codes and sizes.
// No dependencies.
`default_nettype none
package mlf_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] CMD_PHYS = 2'd0;
  localparam logic [1:0] CMD_VIRT = 2'd1;
  localparam logic [1:0] CMD_PROG = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic TBL_ING = 1'b0;
  localparam logic TBL_EGR = 1'b1;

  typedef struct packed {
    logic [47:0] key;
    logic [15:0] port;
    logic [63:0] packets;
    logic [63:0] bytes;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd;
    logic step;
    logic mark_hit;
    logic mark_miss;
    logic act;
    logic load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_end;
    logic key_eq;
    logic again;
    logic can_load;
  } dp_stat_t;

endpackage
`default_nettype wire

### hw/rtl/mlf_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on nothing.
`default_nettype none
interface mlf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [47:0] mac;
  logic [15:0] in_port;
  logic [15:0] frame_length;
  logic [15:0] program_port;
  logic        table_select;
  modport source (output valid, command, mac, in_port, frame_length, program_port,
                  table_select, input ready);
  modport sink (input valid, command, mac, in_port, frame_length, program_port,
                table_select, output ready);
endinterface

interface mlf_rsp_if;
  logic        valid;
  logic        ready;
  logic        forward;
  logic [15:0] out_port;
  logic [1:0]  status;
  logic [63:0] packet_count;
  logic [63:0] byte_count;
  modport source (output valid, forward, out_port, status, packet_count, byte_count,
                  input ready);
  modport sink (input valid, forward, out_port, status, packet_count, byte_count,
                output ready);
endinterface
`default_nettype wire

### hw/rtl/mac_learning_forward_table_unit.sv
// Top level of the MAC learning forward table.
// Depends on mlf_pkg, mlf_if, mlf_ctrl, mlf_datapath (and mlf_ram beneath it).
//
// Use:
//  - req (sink) carries one command per transaction: physical-side frame,
//    virtual-side frame, program ingress entry or read counters.
//  - rsp (source) carries exactly one result transaction per request.
//  - Both tables are occupied from slot 0 upward with no holes (nothing is
//    ever removed), so a fill count per table stands in for valid bits and
//    the next free slot is the fill count itself.
//  - Lookup is a linear scan of a single-port RAM, a read step and then a
//    compare step per occupied slot examined; a physical-side frame that
//    hits scans ingress then egress.
//  - Worst case therefore grows with table occupancy (up to 4096 slots).
//  - One item is in work at a time; req.ready is high only when idle.
//  - The result register lets a new request be taken while the previous
//    result still waits; a finished item holds in its last step until the
//    result register is free.
//  - Reset (rst, synchronous) empties both tables at once by clearing the
//    fill counts; there is no clearing pass. Memory contents are not reset.
//  - A stalled receiver holds rsp stable until taken.
`default_nettype none
module mac_learning_forward_table_unit (
  input  wire logic clk,
  input  wire logic rst,
  mlf_req_if.sink   req,
  mlf_rsp_if.source rsp
);
  mlf_pkg::ctrl_cmd_t cmd;
  mlf_pkg::dp_stat_t  stat;

  mlf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mlf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .command      (req.command),
    .mac          (req.mac),
    .in_port      (req.in_port),
    .frame_length (req.frame_length),
    .program_port (req.program_port),
    .table_select (req.table_select),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .forward      (rsp.forward),
    .out_port     (rsp.out_port),
    .status       (rsp.status),
    .packet_count (rsp.packet_count),
    .byte_count   (rsp.byte_count)
  );
endmodule
`default_nettype wire

### hw/rtl/mlf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module mlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

### hw/rtl/mlf_ctrl.sv
// Sequencer for the table scan, update and result hand-off.
// Depends on mlf_pkg.
`default_nettype none
module mlf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire mlf_pkg::dp_stat_t  stat,
  output mlf_pkg::ctrl_cmd_t      cmd
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_CMP  = 5'b00100,
    S_ACT  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat.at_end) begin
          cmd.mark_miss = 1'b1;
          state_next    = S_ACT;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.key_eq) begin
          cmd.mark_hit = 1'b1;
          state_next   = S_ACT;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_ACT: begin
        cmd.act    = 1'b1;
        state_next = stat.again ? S_LOOK : S_FIN;
      end
      S_FIN: begin
        if (stat.can_load) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### hw/rtl/mlf_datapath.sv
// Table memories, fill counts, scan pointer, entry update and result register.
// Depends on mlf_pkg and mlf_ram.
`default_nettype none
module mlf_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mlf_pkg::ctrl_cmd_t cmd,
  output mlf_pkg::dp_stat_t       stat,
  input  wire logic [1:0]         command,
  input  wire logic [47:0]        mac,
  input  wire logic [15:0]        in_port,
  input  wire logic [15:0]        frame_length,
  input  wire logic [15:0]        program_port,
  input  wire logic               table_select,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output logic                    forward,
  output logic [15:0]             out_port,
  output logic [1:0]              status,
  output logic [63:0]             packet_count,
  output logic [63:0]             byte_count
);
  localparam int IW = mlf_pkg::IDX_W;
  localparam int CW = mlf_pkg::CNT_W;
  localparam logic [CW-1:0] FULL = CW'(mlf_pkg::TABLE_ENTRIES);

  // captured request
  logic [1:0]  c_cmd;
  logic [47:0] c_mac;
  logic [15:0] c_in_port, c_len, c_pport;

  logic          tsel, phase, hit;
  logic [CW-1:0] idx, icount, ecount;
  logic          p_fwd;
  logic [15:0]   p_port;
  logic [1:0]    p_status;
  logic [63:0]   p_pk, p_by;

  logic            we_i, we_e;
  logic [IW-1:0]   waddr, addr;
  mlf_pkg::entry_t wentry, rd_i, rd_e, rd;
  logic [CW-1:0]   count_sel;
  logic            full_sel;
  logic [63:0]     new_pk, new_by;

  assign rd        = (tsel == mlf_pkg::TBL_EGR) ? rd_e : rd_i;
  assign count_sel = (tsel == mlf_pkg::TBL_EGR) ? ecount : icount;
  assign full_sel  = (count_sel == FULL);
  assign new_pk    = rd.packets + 64'd1;
  assign new_by    = rd.bytes + {48'd0, c_len};
  assign waddr     = hit ? idx[IW-1:0] : count_sel[IW-1:0];
  assign addr      = (we_i || we_e) ? waddr : idx[IW-1:0];

  assign stat.at_end   = (idx == count_sel);
  assign stat.key_eq   = (rd.key == c_mac);
  assign stat.again    = (c_cmd == mlf_pkg::CMD_PHYS) && !phase && hit;
  assign stat.can_load = !rsp_valid || rsp_ready;

  // write decision for the update step
  always_comb begin
    we_i   = 1'b0;
    we_e   = 1'b0;
    wentry = rd;
    if (cmd.act) begin
      case (c_cmd)
        mlf_pkg::CMD_PHYS: begin
          if (!phase) begin
            we_i           = hit;
            wentry.packets = new_pk;
            wentry.bytes   = new_by;
          end else begin
            we_e   = hit || !full_sel;
            wentry = hit ? mlf_pkg::entry_t'{key: c_mac, port: c_in_port,
                                             packets: rd.packets, bytes: rd.bytes}
                         : mlf_pkg::entry_t'{key: c_mac, port: c_in_port,
                                             packets: 64'd0, bytes: 64'd0};
          end
        end
        mlf_pkg::CMD_VIRT: begin
          we_e           = hit;
          wentry.packets = new_pk;
          wentry.bytes   = new_by;
        end
        mlf_pkg::CMD_PROG: begin
          we_i   = hit || !full_sel;
          wentry = '{key: c_mac, port: c_pport, packets: 64'd0, bytes: 64'd0};
        end
        default: ;
      endcase
    end
  end

  mlf_ram #(.WIDTH(mlf_pkg::ENTRY_W), .DEPTH(mlf_pkg::TABLE_ENTRIES)) u_ing (
    .clk(clk), .we(we_i), .re(cmd.rd && tsel == mlf_pkg::TBL_ING), .addr(addr),
    .wdata(wentry), .rdata(rd_i)
  );

  mlf_ram #(.WIDTH(mlf_pkg::ENTRY_W), .DEPTH(mlf_pkg::TABLE_ENTRIES)) u_egr (
    .clk(clk), .we(we_e), .re(cmd.rd && tsel == mlf_pkg::TBL_EGR), .addr(addr),
    .wdata(wentry), .rdata(rd_e)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_cmd     <= command;
      c_mac     <= mac;
      c_in_port <= in_port;
      c_len     <= frame_length;
      c_pport   <= program_port;
      idx       <= '0;
      phase     <= 1'b0;
      case (command)
        mlf_pkg::CMD_VIRT: tsel <= mlf_pkg::TBL_EGR;
        mlf_pkg::CMD_READ: tsel <= table_select;
        default:           tsel <= mlf_pkg::TBL_ING;
      endcase
    end
    if (cmd.step)      idx <= idx + CW'(1);
    if (cmd.mark_hit)  hit <= 1'b1;
    if (cmd.mark_miss) hit <= 1'b0;
    if (cmd.act) begin
      // default outcome: miss
      p_fwd    <= 1'b0;
      p_port   <= 16'd0;
      p_status <= mlf_pkg::ST_MISS;
      p_pk     <= 64'd0;
      p_by     <= 64'd0;
      case (c_cmd)
        mlf_pkg::CMD_PHYS: begin
          if (!phase) begin
            if (hit) begin
              p_pk  <= new_pk;
              p_by  <= new_by;
              p_port <= rd.port;
              phase <= 1'b1;
              tsel  <= mlf_pkg::TBL_EGR;
              idx   <= '0;
            end
          end else begin
            p_pk <= p_pk;
            p_by <= p_by;
            if (hit || !full_sel) begin
              p_fwd    <= 1'b1;
              p_port   <= p_port;
              p_status <= mlf_pkg::ST_OK;
            end else begin
              p_status <= mlf_pkg::ST_FULL;
            end
          end
        end
        mlf_pkg::CMD_VIRT: begin
          if (hit) begin
            p_fwd    <= 1'b1;
            p_port   <= rd.port;
            p_status <= mlf_pkg::ST_OK;
            p_pk     <= new_pk;
            p_by     <= new_by;
          end
        end
        mlf_pkg::CMD_PROG: begin
          if (hit || !full_sel) begin
            p_port   <= c_pport;
            p_status <= mlf_pkg::ST_OK;
          end else begin
            p_status <= mlf_pkg::ST_FULL;
          end
        end
        default: begin
          if (hit) begin
            p_port   <= rd.port;
            p_status <= mlf_pkg::ST_OK;
            p_pk     <= rd.packets;
            p_by     <= rd.bytes;
          end
        end
      endcase
    end
    if (cmd.load) begin
      forward      <= p_fwd;
      out_port     <= p_port;
      status       <= p_status;
      packet_count <= p_pk;
      byte_count   <= p_by;
    end
  end

  // fill counts and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      icount    <= '0;
      ecount    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (we_i && !hit) icount <= icount + CW'(1);
      if (we_e && !hit) ecount <= ecount + CW'(1);
      if (cmd.load)          rsp_valid <= 1'b1;
      else if (rsp_ready)    rsp_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### tb/sv/tb_mlf_pkg.sv
// Testbench helpers for the MAC learning forward table: request and result records.
// Depends on mlf_pkg.
package tb_mlf_pkg;
  import mlf_pkg::*;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] mac;
    logic [15:0] in_port;
    logic [15:0] frame_length;
    logic [15:0] program_port;
    logic        table_select;
  } lookup_req_t;

  typedef struct packed {
    logic        forward;
    logic [15:0] out_port;
    logic [1:0]  status;
    logic [63:0] packet_count;
    logic [63:0] byte_count;
  } lookup_rsp_t;
endpackage

### tb/sv/tb_mlf_if.sv
// Testbench-side notes on the channel interfaces.
// The interfaces themselves come from hw/rtl/mlf_if.sv; this file holds a small
// idle-level helper package so the file order stays package, interfaces, top.
package tb_mlf_idle_pkg;
  localparam int MAX_GAP = 17;
endpackage

### tb/sv/testbench.sv
// Self-checking testbench for mac_learning_forward_table_unit.
// Depends on mlf_pkg, mlf_if, tb_mlf_pkg, tb_mlf_idle_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mlf_pkg::*;
  import tb_mlf_pkg::*;
  import tb_mlf_idle_pkg::*;

  // A small MAC pool keeps scans short; model occupancy stays well below 4096.
  localparam int MAC_POOL = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mlf_req_if req();
  mlf_rsp_if rsp();

  mac_learning_forward_table_unit DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial forever #5 clk = ~clk;

  // Expected-result model: one table per direction, filled from slot 0 upward.
  logic [47:0] ing_key[$];
  logic [15:0] ing_port[$];
  logic [63:0] ing_pkts[$];
  logic [63:0] ing_bytes[$];
  logic [47:0] egr_key[$];
  logic [15:0] egr_port[$];
  logic [63:0] egr_pkts[$];
  logic [63:0] egr_bytes[$];

  lookup_req_t  pending_reqs[$];
  lookup_rsp_t  expected_rsps[$];
  logic [47:0]  mac_pool[MAC_POOL];

  int  errors = 0;
  int  n_sent = 0;
  int  n_seen = 0;
  bit  stim_done = 1'b0;
  bit  hold_rx = 1'b0;     // long receiver hold-off request
  int  hit_cnt = 0;
  int  full_cnt = 0;

  function automatic int find_ing(logic [47:0] k);
    foreach (ing_key[i]) if (ing_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_egr(logic [47:0] k);
    foreach (egr_key[i]) if (egr_key[i] == k) return i;
    return -1;
  endfunction

  // Forwarding decision and counter update for one accepted transaction.
  function automatic lookup_rsp_t forward_decision(lookup_req_t r);
    lookup_rsp_t o;
    int i;
    int e;
    o = '{forward: 1'b0, out_port: '0, status: ST_MISS, packet_count: '0, byte_count: '0};
    case (r.command)
      CMD_PHYS: begin
        i = find_ing(r.mac);
        if (i >= 0) begin
          ing_pkts[i] += 64'd1;
          ing_bytes[i] += 64'(r.frame_length);
          o.packet_count = ing_pkts[i];
          o.byte_count = ing_bytes[i];
          e = find_egr(r.mac);
          if (e >= 0) egr_port[e] = r.in_port;
          else if (egr_key.size() < TABLE_ENTRIES) begin
            egr_key.push_back(r.mac);
            egr_port.push_back(r.in_port);
            egr_pkts.push_back('0);
            egr_bytes.push_back('0);
            e = egr_key.size() - 1;
          end
          if (e < 0) o.status = ST_FULL;
          else begin
            o.status = ST_OK;
            o.forward = 1'b1;
            o.out_port = ing_port[i];
          end
        end
      end
      CMD_VIRT: begin
        i = find_egr(r.mac);
        if (i >= 0) begin
          egr_pkts[i] += 64'd1;
          egr_bytes[i] += 64'(r.frame_length);
          o.packet_count = egr_pkts[i];
          o.byte_count = egr_bytes[i];
          o.status = ST_OK;
          o.forward = 1'b1;
          o.out_port = egr_port[i];
        end
      end
      CMD_PROG: begin
        i = find_ing(r.mac);
        if (i < 0 && ing_key.size() < TABLE_ENTRIES) begin
          ing_key.push_back(r.mac);
          ing_port.push_back('0);
          ing_pkts.push_back('0);
          ing_bytes.push_back('0);
          i = ing_key.size() - 1;
        end
        if (i < 0) o.status = ST_FULL;
        else begin
          ing_port[i] = r.program_port;
          ing_pkts[i] = '0;
          ing_bytes[i] = '0;
          o.status = ST_OK;
          o.out_port = r.program_port;
        end
      end
      default: begin
        if (r.table_select == TBL_EGR) begin
          i = find_egr(r.mac);
          if (i >= 0) begin
            o.status = ST_OK;
            o.out_port = egr_port[i];
            o.packet_count = egr_pkts[i];
            o.byte_count = egr_bytes[i];
          end
        end else begin
          i = find_ing(r.mac);
          if (i >= 0) begin
            o.status = ST_OK;
            o.out_port = ing_port[i];
            o.packet_count = ing_pkts[i];
            o.byte_count = ing_bytes[i];
          end
        end
      end
    endcase
    return o;
  endfunction

  function automatic lookup_req_t make_req(logic [1:0] c, logic [47:0] m);
    lookup_req_t r;
    r.command = c;
    r.mac = m;
    r.in_port = 16'($urandom);
    r.frame_length = 16'($urandom);
    r.program_port = 16'($urandom);
    r.table_select = 1'($urandom);
    return r;
  endfunction

  // Driver: takes items from pending_reqs, random gap before each one.
  int gap_left = 0;
  initial begin
    req.valid = 1'b0;
    req.command = CMD_PHYS;
    req.mac = '0;
    req.in_port = '0;
    req.frame_length = '0;
    req.program_port = '0;
    req.table_select = 1'b0;
    rsp.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) begin
        // transaction accepted: predict now, in acceptance order
        expected_rsps.push_back(forward_decision(pending_reqs.pop_front()));
        n_sent++;
        gap_left = $urandom_range(0, MAX_GAP) * ($urandom_range(0, 2) == 0);
      end
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        if (gap_left > 0) gap_left--;
        req.valid <= 1'b0;
      end else begin
        req.valid <= 1'b1;
        {req.command, req.mac, req.in_port, req.frame_length, req.program_port,
         req.table_select} <= pending_reqs[0];
      end
    end
  end

  // Monitor and receiver stall.
  int stall_left = 0;
  always @(posedge clk) begin
    lookup_rsp_t got;
    lookup_rsp_t exp_rsp;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.forward, rsp.out_port, rsp.status, rsp.packet_count, rsp.byte_count};
        n_seen++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (got.forward != exp_rsp.forward)
            $display("%0t: forward exp %0h got %0h", $time, exp_rsp.forward, got.forward);
          if (got.out_port != exp_rsp.out_port)
            $display("%0t: out_port exp %0h got %0h", $time, exp_rsp.out_port, got.out_port);
          if (got.status != exp_rsp.status)
            $display("%0t: status exp %0d got %0d", $time, exp_rsp.status, got.status);
          if (got.packet_count != exp_rsp.packet_count)
            $display("%0t: packet_count exp %0h got %0h", $time, exp_rsp.packet_count,
                     got.packet_count);
          if (got.byte_count != exp_rsp.byte_count)
            $display("%0t: byte_count exp %0h got %0h", $time, exp_rsp.byte_count,
                     got.byte_count);
          if (got != exp_rsp) errors++;
          if (exp_rsp.forward) hit_cnt++;
          if (exp_rsp.status == ST_FULL) full_cnt++;
        end
        stall_left = $urandom_range(0, MAX_GAP) * ($urandom_range(0, 2) == 0);
      end
      if (hold_rx) begin
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Stimulus.
  initial begin
    lookup_req_t r;
    int k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
    mac_pool[0] = '0;
    mac_pool[1] = '1;

    // Directed: misses on empty tables, programming, extremes, relearn, reprogram.
    pending_reqs.push_back(make_req(CMD_PHYS, mac_pool[0]));
    pending_reqs.push_back(make_req(CMD_VIRT, mac_pool[1]));
    r = make_req(CMD_READ, mac_pool[0]); r.table_select = TBL_ING; pending_reqs.push_back(r);
    r = make_req(CMD_READ, mac_pool[0]); r.table_select = TBL_EGR; pending_reqs.push_back(r);
    r = make_req(CMD_PROG, mac_pool[0]); r.program_port = '0; pending_reqs.push_back(r);
    r = make_req(CMD_PROG, mac_pool[1]); r.program_port = '1; pending_reqs.push_back(r);
    r = make_req(CMD_PHYS, mac_pool[0]); r.frame_length = '1; r.in_port = '1;
    pending_reqs.push_back(r);
    r = make_req(CMD_PHYS, mac_pool[0]); r.frame_length = '0; r.in_port = '0;
    pending_reqs.push_back(r);
    r = make_req(CMD_PHYS, mac_pool[1]); r.frame_length = '1; pending_reqs.push_back(r);
    r = make_req(CMD_VIRT, mac_pool[0]); r.frame_length = '1; pending_reqs.push_back(r);
    r = make_req(CMD_VIRT, mac_pool[1]); r.frame_length = '0; pending_reqs.push_back(r);
    r = make_req(CMD_READ, mac_pool[0]); r.table_select = TBL_ING; pending_reqs.push_back(r);
    r = make_req(CMD_READ, mac_pool[0]); r.table_select = TBL_EGR; pending_reqs.push_back(r);
    r = make_req(CMD_PROG, mac_pool[0]); pending_reqs.push_back(r);   // reprogram clears counts
    r = make_req(CMD_READ, mac_pool[0]); r.table_select = TBL_ING; pending_reqs.push_back(r);
    r = make_req(CMD_READ, mac_pool[1]); r.table_select = TBL_EGR; pending_reqs.push_back(r);
    r = make_req(CMD_VIRT, mac_pool[2]); pending_reqs.push_back(r);

    // Random: mostly known MACs so lookups hit and counters accumulate.
    for (int n = 0; n < 1000; n++) begin
      if (n == 300) begin
        // sender pause until all outstanding results have arrived
        wait (pending_reqs.size() == 0);
        wait (expected_rsps.size() == 0);
      end
      if (n == 600) begin
        // receiver holds off while the sender keeps offering
        hold_rx = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk);
            hold_rx = 1'b0;
          end
        join_none
      end
      k = $urandom_range(0, 9);
      r = make_req(2'($urandom), (k == 0) ? 48'({$urandom, $urandom}) :
                   mac_pool[$urandom_range(0, MAC_POOL - 1)]);
      if (r.command == CMD_PROG && $urandom_range(0, 3) != 0) r.command = CMD_PHYS;
      pending_reqs.push_back(r);
      while (pending_reqs.size() > 8) @(posedge clk);
    end

    wait (pending_reqs.size() == 0);
    stim_done = 1'b1;
  end

  // End of run.
  initial begin
    wait (stim_done);
    wait (expected_rsps.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d requests, checked %0d results (%0d forwarded, %0d table full).",
             n_sent, n_seen, hit_cnt, full_cnt);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", expected_rsps.size());
    $display("Test completed with failures");
    $finish;
  end
endmodule
